FILE: sv/vca_pkg.sv
// Shared types and constants for the voice channel allocator.
package vca_pkg;

    localparam int KEY_W       = 16;
    localparam int FUNC_W      = 2;
    localparam int HANDLE_W    = 5;
    localparam int COUNT_W     = 6;
    localparam int CFG_W       = 6;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;
    localparam logic [CFG_W-1:0] POOL_MIN  = 6'd4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ASSIGN  = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_LOOKUP  = 2'd2
    } t_func;

    typedef struct packed {
        logic pop;
        logic push;
    } t_fl_cmd;

    typedef struct packed {
        logic can_pop;
        logic free_left;
    } t_fl_status;

    typedef struct packed {
        logic bind_key;
        logic unbind;
    } t_cam_cmd;

endpackage

FILE: sv/voice_channel_allocator_core.sv
// Top level of the voice channel allocator: request register, control and result register.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: func; tdata: source_id, stop_flag
//   m_axis    out        tdata: ok, handle, was_playing, stop_request, active_count, free_left
//   cfg       in         wdata: handle_count
//
// A request beat is registered, resolved combinationally and lands in the result register,
// so one beat per cycle is sustained while the output is not stalled.
// The key search compares the key against every bound handle in parallel.
// Reset is synchronous; afterwards handle_count is 32, the pool holds that many handles (at most MAX_HANDLES)
// and no source is bound. A stalled result holds the request register; the input side keeps taking beats while
// the request register is empty or about to drain.
module voice_channel_allocator_core #(
    parameter int MAX_HANDLES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] source_id, [16] stop_flag, [23:17] zero
    input  logic [vca_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] func
    input  logic [vca_pkg::FUNC_W-1:0]        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] ok, [5:1] handle, [6] was_playing, [7] stop_request,
    // [13:8] active_count, [14] free_left, [15] zero
    output logic [vca_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [vca_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_HANDLES);
    localparam int CNT_W  = $clog2(MAX_HANDLES + 1);
    localparam int HEXT_W = IDX_W + vca_pkg::HANDLE_W;
    localparam int CEXT_W = CNT_W + vca_pkg::COUNT_W;

    logic [vca_pkg::CFG_W-1:0]      r_handle_count;
    logic                           r_in_valid;
    logic [vca_pkg::FUNC_W-1:0]     r_func;
    logic [vca_pkg::KEY_W-1:0]      r_key;
    logic                           r_stop;
    logic                           r_out_valid;
    logic [vca_pkg::M_TDATA_W-1:0]  r_out_data;
    logic [vca_pkg::M_TDATA_W-1:0]  n_out_data;
    logic [CNT_W-1:0]               r_bound_total;
    logic [CNT_W-1:0]               n_bound_total;

    logic                           process;
    logic                           hit;
    logic [IDX_W-1:0]               hit_idx;
    logic [IDX_W-1:0]               pop_handle;
    logic [IDX_W-1:0]               wr_idx;
    logic [IDX_W-1:0]               res_idx;
    vca_pkg::t_cam_cmd              cam_cmd;
    vca_pkg::t_fl_cmd               fl_cmd;
    vca_pkg::t_fl_status            fl_status;
    logic                           res_ok;
    logic                           res_was;
    logic                           res_stop;
    logic [HEXT_W-1:0]              handle_ext;
    logic [CEXT_W-1:0]              count_ext;

    assign process         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || process;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    vca_cam #(
        .MAX_HANDLES (MAX_HANDLES)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (r_key),
        .i_cmd     (cam_cmd),
        .i_wr_idx  (wr_idx),
        .o_hit     (hit),
        .o_hit_idx (hit_idx)
    );

    vca_free_list #(
        .MAX_HANDLES (MAX_HANDLES)
    ) u_free_list (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_handle_count (r_handle_count),
        .i_cmd          (fl_cmd),
        .i_push_handle  (hit_idx),
        .o_pop_handle   (pop_handle),
        .o_status       (fl_status)
    );

    always_comb begin
        cam_cmd       = '0;
        fl_cmd        = '0;
        res_ok        = 1'b0;
        res_was       = 1'b0;
        res_stop      = 1'b0;
        res_idx       = '0;
        wr_idx        = hit ? hit_idx : pop_handle;
        n_bound_total = r_bound_total;
        unique case (r_func)
            vca_pkg::FUNC_ASSIGN: begin
                if (hit) begin
                    res_ok  = 1'b1;
                    res_was = 1'b1;
                    res_idx = hit_idx;
                end else if (fl_status.can_pop) begin
                    cam_cmd.bind_key = process;
                    fl_cmd.pop       = process;
                    res_ok           = 1'b1;
                    res_idx          = pop_handle;
                    n_bound_total    = r_bound_total + 1'b1;
                end
            end
            vca_pkg::FUNC_RELEASE: begin
                if (hit) begin
                    cam_cmd.unbind = process;
                    fl_cmd.push    = process;
                    res_ok         = 1'b1;
                    res_stop       = r_stop;
                    res_idx        = hit_idx;
                    if (r_bound_total != '0) begin
                        n_bound_total = r_bound_total - 1'b1;
                    end
                end
            end
            vca_pkg::FUNC_LOOKUP: begin
                if (hit) begin
                    res_ok  = 1'b1;
                    res_idx = hit_idx;
                end
            end
            default: begin
            end
        endcase
        handle_ext = HEXT_W'(res_idx);
        count_ext  = CEXT_W'(n_bound_total);
        n_out_data = {1'b0, fl_status.free_left, count_ext[vca_pkg::COUNT_W-1:0],
                      res_stop, res_was, handle_ext[vca_pkg::HANDLE_W-1:0], res_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handle_count <= vca_pkg::CFG_RESET;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_bound_total  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_handle_count <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (process) begin
                r_out_valid   <= 1'b1;
                r_bound_total <= n_bound_total;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_func <= i_s_axis_tuser;
            r_key  <= i_s_axis_tdata[vca_pkg::KEY_W-1:0];
            r_stop <= i_s_axis_tdata[vca_pkg::KEY_W];
        end
        if (process) begin
            r_out_data <= n_out_data;
        end
    end

    a_handle_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[5:1] == '0))
        else $error("failed beat carries a nonzero handle");

    a_flags_need_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[6] || o_m_axis_tdata[7])) |-> o_m_axis_tdata[0])
        else $error("was_playing or stop_request set without ok");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bound_total <= CNT_W'(MAX_HANDLES))
        else $error("bound total exceeds the handle pool");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !process |=> $stable(r_bound_total))
        else $error("bound total changed without a request");

endmodule

FILE: sv/vca_cam.sv
// Bound-key table with a parallel search for the lowest matching handle.
module vca_cam #(
    parameter int MAX_HANDLES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [vca_pkg::KEY_W-1:0]   i_key,
    input  vca_pkg::t_cam_cmd           i_cmd,
    input  logic [$clog2(MAX_HANDLES)-1:0] i_wr_idx,
    output logic                        o_hit,
    output logic [$clog2(MAX_HANDLES)-1:0] o_hit_idx
);

    localparam int IDX_W = $clog2(MAX_HANDLES);

    logic [vca_pkg::KEY_W-1:0] r_key [MAX_HANDLES];
    logic [MAX_HANDLES-1:0]    r_valid;

    always_comb begin
        o_hit     = 1'b0;
        o_hit_idx = '0;
        for (int i = MAX_HANDLES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                o_hit     = 1'b1;
                o_hit_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bind_key) begin
            r_key[i_wr_idx] <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.bind_key) begin
            r_valid[i_wr_idx] <= 1'b1;
        end else if (i_cmd.unbind) begin
            r_valid[i_wr_idx] <= 1'b0;
        end
    end

endmodule

FILE: sv/vca_free_list.sv
// Free handle pool: a counter of never-used handles and a FIFO of returned ones.
module vca_free_list #(
    parameter int MAX_HANDLES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [vca_pkg::CFG_W-1:0]      i_handle_count,
    input  vca_pkg::t_fl_cmd               i_cmd,
    input  logic [$clog2(MAX_HANDLES)-1:0] i_push_handle,
    output logic [$clog2(MAX_HANDLES)-1:0] o_pop_handle,
    output vca_pkg::t_fl_status            o_status
);

    localparam int IDX_W = $clog2(MAX_HANDLES);
    localparam int CNT_W = $clog2(MAX_HANDLES + 1);
    localparam int SZ_W  = (CNT_W > vca_pkg::CFG_W) ? CNT_W : vca_pkg::CFG_W;

    logic [IDX_W-1:0] r_mem [MAX_HANDLES];
    logic [IDX_W-1:0] r_head_data;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] n_head;
    logic [IDX_W-1:0] r_tail;
    logic [IDX_W-1:0] n_tail;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] r_fresh;
    logic [CNT_W-1:0] n_fresh;
    logic [SZ_W-1:0]  cnt_ext;
    logic [SZ_W-1:0]  pool_size;
    logic             can_fresh;
    logic             pop_fresh;
    logic             pop_fifo;
    logic             push_ok;

    always_comb begin
        cnt_ext = SZ_W'(i_handle_count);
        priority if (cnt_ext < SZ_W'(vca_pkg::POOL_MIN)) begin
            pool_size = SZ_W'(vca_pkg::POOL_MIN);
        end else if (cnt_ext > SZ_W'(MAX_HANDLES)) begin
            pool_size = SZ_W'(MAX_HANDLES);
        end else begin
            pool_size = cnt_ext;
        end
    end

    assign can_fresh = SZ_W'(r_fresh) < pool_size;
    assign pop_fresh = i_cmd.pop && can_fresh;
    assign pop_fifo  = i_cmd.pop && !can_fresh && (r_fill != '0);
    assign push_ok   = i_cmd.push && (r_fill < CNT_W'(MAX_HANDLES));

    always_comb begin
        n_fresh = r_fresh;
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        if (pop_fresh) begin
            n_fresh = r_fresh + 1'b1;
        end
        if (pop_fifo) begin
            n_head = (r_head == IDX_W'(MAX_HANDLES - 1)) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
        if (push_ok) begin
            n_tail = (r_tail == IDX_W'(MAX_HANDLES - 1)) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end
    end

    assign o_pop_handle       = can_fresh ? r_fresh[IDX_W-1:0] : r_head_data;
    assign o_status.can_pop   = can_fresh || (r_fill != '0);
    assign o_status.free_left = (SZ_W'(n_fresh) < pool_size) || (n_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_fresh <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_fresh <= n_fresh;
        end
    end

    // The head entry is prefetched; a push into an empty FIFO bypasses the array.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_push_handle;
        end
        if (push_ok && (r_tail == n_head)) begin
            r_head_data <= i_push_handle;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

endmodule
